// ----- rtl/scroll_follow_with_shake_defines.svh -----
// assertion macros for the scroll follower
// the using module must have signals named clock and reset in scope
`ifndef SCROLL_FOLLOW_WITH_SHAKE_DEFINES_SVH
`define SCROLL_FOLLOW_WITH_SHAKE_DEFINES_SVH

// condition holds at every edge out of reset
`define SFWS_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SFWS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sfws_pkg.sv -----
// shared types, codes and constants of the scroll follower
// no dependencies; used by sfws_lane, sfws_merge and scroll_follow_with_shake
package sfws_pkg;

   localparam int NUM_LANES   = 2;
   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 128;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 31;

   // request kinds
   localparam logic [2:0] REQ_TICK   = 3'd0;
   localparam logic [2:0] REQ_PAN    = 3'd1;
   localparam logic [2:0] REQ_SNAP   = 3'd2;
   localparam logic [2:0] REQ_FOLLOW = 3'd3;
   localparam logic [2:0] REQ_SHAKE  = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_MAX_SCROLL_X = 3'd0;
   localparam logic [2:0] CSR_MAX_SCROLL_Y = 3'd1;
   localparam logic [2:0] CSR_SHAKE_AMP_X  = 3'd2;
   localparam logic [2:0] CSR_SHAKE_AMP_Y  = 3'd3;
   localparam logic [2:0] CSR_SHAKE_LEN_X  = 3'd4;
   localparam logic [2:0] CSR_SHAKE_LEN_Y  = 3'd5;

   localparam logic [31:0] EASE_BOOST_BASE = 32'd16000;
   localparam logic [29:0] VEL_STEP        = 30'd10;
   // reciprocals: x/5 for 32-bit x, 8a/5 for 19-bit 8a, x/20 for 22-bit x
   localparam logic [31:0] DIV5_MUL32      = 32'hCCCC_CCCD;
   localparam logic [19:0] AMP_DIV5_MUL    = 20'd838861;
   localparam logic [22:0] FADE_DIV20_MUL  = 23'd6710887;
   localparam logic [15:0] FADE_TICKS      = 16'd20;
   localparam logic [9:0]  LVL_FULL        = 10'd1000;
   localparam logic [9:0]  LVL_STEP        = 10'd500;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] target;
      logic [30:0]        far_edge;
      logic [15:0]        amp;
      logic [15:0]        len;
      logic [29:0]        rate_limit;
      logic               boost;
   } lane_cmd_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] view;
      logic signed [31:0] jitter;
   } lane_status_type;

endpackage

// ----- rtl/sfws_lane.sv -----
// one axis of the scroll follower: easing towards the goal and shake offset
// depends on sfws_pkg
module sfws_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  sfws_pkg::lane_cmd_type    cmd,
   output sfws_pkg::lane_status_type status
);
   import sfws_pkg::*;

   typedef enum logic [2:0] {
      L_IDLE, L_EASE_MUL, L_EASE_UPD, L_SHK_TICK, L_SHK_FADE, L_SHK_WIN, L_SHK_OUT
   } lane_state_type;

   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      logic [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -36'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // architectural state
   lane_state_type     state_ff, state_in;
   logic               done_ff, done_in;
   logic signed [31:0] pos_ff, pos_in;
   logic [29:0]        vel_ff, vel_in;
   logic [30:0]        goal_ff, goal_in;
   logic               on_ff, on_in;
   logic [15:0]        ticks_ff, ticks_in;
   logic               falling_ff, falling_in;
   logic [9:0]         level_ff, level_in;
   logic signed [31:0] jitter_ff, jitter_in;

   // datapath temporaries
   logic [62:0]        ease_mul_ff, ease_mul_in;
   logic               far_ff, far_in;
   logic               lt_ff, lt_in;
   logic               dir_ff, dir_in;
   logic [38:0]        amp_mul_ff, amp_mul_in;
   logic [16:0]        amp_ff;
   logic [21:0]        fade_mul_ff, fade_mul_in;
   logic               fade_ff, fade_in;
   logic [16:0]        amp_eff_ff, amp_eff_in;
   logic signed [35:0] lower_ff, lower_in;
   logic signed [35:0] upper_ff, upper_in;

   logic [30:0]        goal_clamp;
   logic signed [32:0] diff;
   logic [31:0]        gap_len;
   logic [31:0]        far_sub;
   logic [28:0]        extra;
   logic [30:0]        step;
   logic signed [33:0] pos_wide;
   logic [31:0]        pos_sat;
   logic [30:0]        vel_inc;
   logic [29:0]        vel_cap;
   logic [29:0]        vel_dec;
   logic [15:0]        tick_n;
   logic [15:0]        rem;
   logic [44:0]        fade_prod;
   logic signed [35:0] cur36, a36, ms36, low_try;
   logic               at_low, hit;
   logic signed [35:0] span, span_rnd, scaled, jit36;
   logic [10:0]        lvl_up;

   always_comb begin
      // goal clamped to [0, far edge]
      if (cmd.target[31]) begin
         goal_clamp = '0;
      end else if (cmd.target[30:0] > cmd.far_edge) begin
         goal_clamp = cmd.far_edge;
      end else begin
         goal_clamp = cmd.target[30:0];
      end

      // easing, first half: distance and boost quotient
      diff    = $signed({2'b00, goal_ff}) - $signed({pos_ff[31], pos_ff});
      gap_len = diff[32] ? 32'(-diff) : diff[31:0];
      dir_in  = !diff[32];
      lt_in   = {2'b00, vel_ff} < gap_len;
      far_in  = cmd.boost && (gap_len > EASE_BOOST_BASE);
      far_sub = gap_len - EASE_BOOST_BASE;
      // (d-16000)/10 as ((d-16000)>>1)/5
      ease_mul_in = far_sub[31:1] * DIV5_MUL32;

      // easing, second half
      extra    = far_ff ? ease_mul_ff[62:34] : '0;
      step     = {1'b0, vel_ff} + {2'b00, extra};
      pos_wide = dir_ff ? $signed({{2{pos_ff[31]}}, pos_ff}) + $signed({3'b000, step})
                        : $signed({{2{pos_ff[31]}}, pos_ff}) - $signed({3'b000, step});
      pos_sat  = sat32($signed({{2{pos_wide[33]}}, pos_wide}));
      vel_inc  = {1'b0, vel_ff} + {1'b0, VEL_STEP};
      vel_cap  = (vel_inc > {1'b0, cmd.rate_limit}) ? cmd.rate_limit : vel_inc[29:0];
      vel_dec  = (vel_ff >= VEL_STEP) ? vel_ff - VEL_STEP : '0;

      // amplitude 8a/5, then fade in the closing ticks
      amp_mul_in  = {cmd.amp, 3'b000} * AMP_DIV5_MUL;
      tick_n      = ticks_ff + 16'd1;
      rem         = cmd.len - tick_n;
      fade_in     = (cmd.len != '0) && (rem < FADE_TICKS);
      fade_mul_in = rem[4:0] * amp_ff;
      fade_prod   = fade_mul_ff * FADE_DIV20_MUL;
      amp_eff_in  = fade_ff ? fade_prod[43:27] : amp_ff;

      // window around the position, clamped to the map edges
      cur36    = {{4{pos_ff[31]}}, pos_ff};
      a36      = {19'b0, amp_eff_ff};
      ms36     = {5'b0, cmd.far_edge};
      low_try  = cur36 - a36;
      at_low   = low_try[35];
      lower_in = at_low ? -cur36 : -a36;
      hit      = at_low ? (ms36 < (a36 <<< 1)) : (ms36 < cur36 + a36);
      if (hit) begin
         upper_in = ms36 - cur36;
      end else if (at_low) begin
         upper_in = (a36 <<< 1) - cur36;
      end else begin
         upper_in = a36;
      end

      // level is 0, half or full, so the scale is a shift
      span     = upper_ff - lower_ff;
      span_rnd = span + $signed({35'b0, span[35]});
      if (level_ff == '0) begin
         scaled = '0;
      end else if (level_ff == LVL_FULL) begin
         scaled = span;
      end else begin
         scaled = span_rnd >>> 1;
      end
      jit36  = scaled + lower_ff;
      lvl_up = {1'b0, level_ff} + {1'b0, LVL_STEP};

      // next state
      state_in   = state_ff;
      done_in    = 1'b0;
      pos_in     = pos_ff;
      vel_in     = vel_ff;
      goal_in    = goal_ff;
      on_in      = on_ff;
      ticks_in   = ticks_ff;
      falling_in = falling_ff;
      level_in   = level_ff;
      jitter_in  = jitter_ff;

      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               unique case (cmd.kind)
                  REQ_TICK: begin
                     state_in = L_EASE_MUL;
                  end
                  REQ_PAN, REQ_FOLLOW: begin
                     goal_in = goal_clamp;
                     done_in = 1'b1;
                  end
                  REQ_SNAP: begin
                     goal_in = goal_clamp;
                     pos_in  = {1'b0, goal_clamp};
                     vel_in  = '0;
                     done_in = 1'b1;
                  end
                  REQ_SHAKE: begin
                     on_in      = 1'b1;
                     ticks_in   = '0;
                     level_in   = '0;
                     falling_in = 1'b0;
                     done_in    = 1'b1;
                  end
                  default: begin
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         L_EASE_MUL: begin
            state_in = L_EASE_UPD;
         end
         L_EASE_UPD: begin
            pos_in   = lt_ff ? pos_sat : {1'b0, goal_ff};
            vel_in   = lt_ff ? vel_cap : vel_dec;
            state_in = L_SHK_TICK;
         end
         L_SHK_TICK: begin
            // an idle or ending shake still runs the full sequence so both lanes stay in step
            if (on_ff && (cmd.len != '0)) begin
               ticks_in = tick_n;
               if (tick_n >= cmd.len) begin
                  on_in = 1'b0;
               end
            end
            state_in = L_SHK_FADE;
         end
         L_SHK_FADE: begin
            state_in = L_SHK_WIN;
         end
         L_SHK_WIN: begin
            // rise to full, hold one tick, fall to zero, hold one tick
            if (on_ff) begin
               if (!falling_ff) begin
                  if (level_ff < LVL_FULL) begin
                     level_in = (lvl_up > {1'b0, LVL_FULL}) ? LVL_FULL : lvl_up[9:0];
                  end else begin
                     falling_in = 1'b1;
                  end
               end else if (level_ff == '0) begin
                  falling_in = 1'b0;
               end else begin
                  level_in = (level_ff >= LVL_STEP) ? level_ff - LVL_STEP : '0;
               end
            end
            state_in = L_SHK_OUT;
         end
         L_SHK_OUT: begin
            jitter_in = on_ff ? sat32(jit36) : '0;
            done_in   = 1'b1;
            state_in  = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= L_IDLE;
         done_ff    <= 1'b0;
         pos_ff     <= '0;
         vel_ff     <= '0;
         goal_ff    <= '0;
         on_ff      <= 1'b0;
         ticks_ff   <= '0;
         falling_ff <= 1'b0;
         level_ff   <= '0;
         jitter_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         done_ff    <= done_in;
         pos_ff     <= pos_in;
         vel_ff     <= vel_in;
         goal_ff    <= goal_in;
         on_ff      <= on_in;
         ticks_ff   <= ticks_in;
         falling_ff <= falling_in;
         level_ff   <= level_in;
         jitter_ff  <= jitter_in;
      end
   end

   always_ff @(posedge clock) begin
      amp_mul_ff <= amp_mul_in;
      if (state_ff == L_EASE_MUL) begin
         ease_mul_ff <= ease_mul_in;
         far_ff      <= far_in;
         lt_ff       <= lt_in;
         dir_ff      <= dir_in;
      end
      if (state_ff == L_EASE_UPD) begin
         amp_ff <= amp_mul_ff[38:22];
      end
      if (state_ff == L_SHK_TICK) begin
         fade_mul_ff <= fade_mul_in;
         fade_ff     <= fade_in;
      end
      if (state_ff == L_SHK_FADE) begin
         amp_eff_ff <= amp_eff_in;
      end
      if (state_ff == L_SHK_WIN) begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

   assign status.done   = done_ff;
   assign status.view   = pos_ff;
   assign status.jitter = jitter_ff;

endmodule

// ----- rtl/sfws_merge.sv -----
// merge stage: gathers both axis results into one response register
// depends on sfws_pkg
module sfws_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  sfws_pkg::lane_status_type           lane_st [sfws_pkg::NUM_LANES],
   output logic                                free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // view_x, view_y, jitter_x, jitter_y from the lowest bit up
   output logic [sfws_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import sfws_pkg::*;

   logic                  valid_ff, valid_in;
   logic [RSP_DATA_W-1:0] data_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= {lane_st[1].jitter, lane_st[0].jitter, lane_st[1].view, lane_st[0].view};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ----- rtl/scroll_follow_with_shake.sv -----
// scroll follower top level: registers, request control, two axis lanes, merge.
// a tick runs through the six-step lane sequence (ease multiply, ease update, tick count,
// fade multiply, window, offset); other requests finish in the lane's idle state.
// no new request is taken until the previous one has been loaded into the output register;
// the next request is taken while a response waits in the output register.
// reset: synchronous, active high; clears all positions, speeds, goals and registers.
`include "scroll_follow_with_shake_defines.svh"

module scroll_follow_with_shake (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // new_target_x, new_target_y, pan_rate from the lowest bit up, zero pad
   input  logic [sfws_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type
   input  logic [2:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // view_x, view_y, jitter_x, jitter_y from the lowest bit up
   output logic [sfws_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [sfws_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [sfws_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sfws_pkg::*;

   typedef enum logic [1:0] {T_IDLE, T_RUN, T_POST} top_state_type;

   top_state_type      state_ff, state_in;
   logic               start_ff, start_in;
   logic [29:0]        rate_ff, rate_in;
   logic               boost_ff, boost_in;
   logic [30:0]        max_x_ff, max_y_ff;
   logic [15:0]        amp_x_ff, amp_y_ff, len_x_ff, len_y_ff;
   logic [2:0]         kind_ff;
   logic signed [31:0] tgt_x_ff, tgt_y_ff;

   logic               accept;
   logic               load;
   logic               merge_free;
   lane_cmd_type       lane_cmd [NUM_LANES];
   lane_status_type    lane_st  [NUM_LANES];

   assign req_tready = (state_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load       = (state_ff == T_POST) && merge_free;

   always_comb begin
      state_in = state_ff;
      start_in = 1'b0;
      rate_in  = rate_ff;
      boost_in = boost_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               state_in = T_RUN;
               start_in = 1'b1;
               // rate and boost are shared by both axes
               unique case (req_tuser)
                  REQ_PAN: begin
                     rate_in  = req_tdata[93:64];
                     boost_in = 1'b0;
                  end
                  REQ_FOLLOW: begin
                     rate_in  = req_tdata[93:64];
                     boost_in = 1'b1;
                  end
                  REQ_SNAP: begin
                     rate_in  = '0;
                     boost_in = 1'b0;
                  end
                  default: begin
                     rate_in  = rate_ff;
                  end
               endcase
            end
         end
         T_RUN: begin
            if (lane_st[0].done) begin
               state_in = T_POST;
            end
         end
         T_POST: begin
            if (merge_free) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         start_ff <= 1'b0;
         rate_ff  <= '0;
         boost_ff <= 1'b0;
         max_x_ff <= '0;
         max_y_ff <= '0;
         amp_x_ff <= '0;
         amp_y_ff <= '0;
         len_x_ff <= '0;
         len_y_ff <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         rate_ff  <= rate_in;
         boost_ff <= boost_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_MAX_SCROLL_X: max_x_ff <= csr_wdata;
               CSR_MAX_SCROLL_Y: max_y_ff <= csr_wdata;
               CSR_SHAKE_AMP_X:  amp_x_ff <= csr_wdata[15:0];
               CSR_SHAKE_AMP_Y:  amp_y_ff <= csr_wdata[15:0];
               CSR_SHAKE_LEN_X:  len_x_ff <= csr_wdata[15:0];
               CSR_SHAKE_LEN_Y:  len_y_ff <= csr_wdata[15:0];
               default: begin
                  max_x_ff <= max_x_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_tuser;
         tgt_x_ff <= req_tdata[31:0];
         tgt_y_ff <= req_tdata[63:32];
      end
   end

   always_comb begin
      lane_cmd[0] = '{kind: kind_ff, target: tgt_x_ff, far_edge: max_x_ff, amp: amp_x_ff,
                      len: len_x_ff, rate_limit: rate_ff, boost: boost_ff};
      lane_cmd[1] = '{kind: kind_ff, target: tgt_y_ff, far_edge: max_y_ff, amp: amp_y_ff,
                      len: len_y_ff, rate_limit: rate_ff, boost: boost_ff};
   end

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      sfws_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .start  (start_ff),
         .cmd    (lane_cmd[i]),
         .status (lane_st[i])
      );
   end

   sfws_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .lane_st    (lane_st),
      .free       (merge_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `SFWS_ASSERT_NOW(a_lanes_in_step, lane_st[0].done == lane_st[1].done, "lanes finished out of step")
   `SFWS_ASSERT_IMP(a_done_in_run, lane_st[0].done, state_ff == T_RUN, "lane finished with no request at work")
   `SFWS_ASSERT_IMP(a_rsp_from_load, $rose(rsp_tvalid), $past(state_ff == T_POST), "response raised without a load")

endmodule

// ----- sim/scroll_follow_with_shake_check.sv -----
// checker for the scroll follower: watches the request, response and register ports,
// predicts every response and compares it field by field; depends on sfws_pkg
`timescale 1ns / 100ps

module scroll_follow_with_shake_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // new_target_x, new_target_y, pan_rate from the lowest bit up, zero pad
   input  logic [sfws_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  logic [2:0]                        req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // view_x, view_y, jitter_x, jitter_y from the lowest bit up
   input  logic [sfws_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [sfws_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [sfws_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                fault_count,
   output int                                owed_count
);
   import sfws_pkg::*;

   localparam longint BOOST_BASE = 16000;
   localparam longint BOOST_DIV  = 10;
   localparam longint SPEED_STEP = 10;
   localparam longint AMP_NUM    = 1600;
   localparam longint AMP_DEN    = 1000;
   localparam longint FADE_LEN   = 20;
   localparam longint LEVEL_TOP  = 1000;
   localparam longint LEVEL_STEP = 500;
   localparam longint S32_MAX    = 64'sh7FFF_FFFF;
   localparam longint S32_MIN    = -64'sh8000_0000;

   string field_name [4] = '{"view_x", "view_y", "jitter_x", "jitter_y"};

   // register copies, index 0 is x and 1 is y
   longint edge_lim [2];
   longint amp_raw [2];
   longint shake_len [2];

   // camera state
   longint pos [2];
   longint vel [2];
   longint goal [2];
   longint rate_cap;
   bit     boost;
   bit     shk_on [2];
   longint shk_ticks [2];
   bit     shk_fall [2];
   longint shk_lvl [2];
   longint jit [2];

   logic [RSP_DATA_W-1:0] pending_views [$];

   function automatic longint sat32(input longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   function automatic longint clamp_goal(input logic [31:0] raw, input longint far_edge);
      longint t;
      t = longint'($signed(raw));
      if (t < 0) t = 0;
      if (t > far_edge) t = far_edge;
      return t;
   endfunction

   function automatic void ease_axis(input int a);
      longint c, g, v, gap_len, extra;
      c = pos[a];
      g = goal[a];
      v = vel[a];
      gap_len = (g > c) ? g - c : c - g;
      if (v < gap_len) begin
         extra = 0;
         if (boost && gap_len > BOOST_BASE) extra = (gap_len - BOOST_BASE) / BOOST_DIV;
         c = (c < g) ? c + v + extra : c - v - extra;
         c = sat32(c);
         v = v + SPEED_STEP;
         if (v > rate_cap) v = rate_cap;
      end else begin
         c = g;
         v = v - SPEED_STEP;
         if (v < 0) v = 0;
      end
      pos[a] = c;
      vel[a] = v;
   endfunction

   function automatic void shake_axis(input int a);
      longint amp, cur, lower, upper, lvl, left;
      amp = amp_raw[a] * AMP_NUM / AMP_DEN;
      cur = pos[a];
      if (!shk_on[a]) begin
         jit[a] = 0;
         return;
      end
      if (shake_len[a] > 0) begin
         shk_ticks[a] = (shk_ticks[a] + 1) % 65536;
         if (shk_ticks[a] >= shake_len[a]) begin
            shk_on[a] = 1'b0;
            jit[a] = 0;
            return;
         end
         left = shake_len[a] - shk_ticks[a];
         if (left < FADE_LEN) amp = left * amp / FADE_LEN;
      end
      // window around the position, pushed off the near edge then cut at the far one
      lower = -amp;
      upper = 0;
      if (lower + cur < 0) begin
         lower = -cur;
         upper = lower + amp;
      end
      upper = upper + amp;
      if (edge_lim[a] < upper + cur) upper = edge_lim[a] - cur;

      lvl = shk_lvl[a];
      if (!shk_fall[a]) begin
         if (lvl < LEVEL_TOP) begin
            lvl = lvl + LEVEL_STEP;
            if (lvl > LEVEL_TOP) lvl = LEVEL_TOP;
         end else begin
            shk_fall[a] = 1'b1;
         end
      end else if (lvl == 0) begin
         shk_fall[a] = 1'b0;
      end else begin
         lvl = lvl - LEVEL_STEP;
         if (lvl < 0) lvl = 0;
      end
      shk_lvl[a] = lvl;
      jit[a] = sat32(lvl * (upper - lower) / LEVEL_TOP + lower);
   endfunction

   function automatic logic [RSP_DATA_W-1:0] advance_camera(input logic [2:0] kind,
                                                             input logic [REQ_DATA_W-1:0] data);
      case (kind)
         REQ_TICK: begin
            ease_axis(0);
            ease_axis(1);
            shake_axis(0);
            shake_axis(1);
         end
         REQ_PAN, REQ_FOLLOW: begin
            goal[0] = clamp_goal(data[31:0], edge_lim[0]);
            goal[1] = clamp_goal(data[63:32], edge_lim[1]);
            rate_cap = longint'(data[93:64]);
            boost = (kind == REQ_FOLLOW);
         end
         REQ_SNAP: begin
            goal[0] = clamp_goal(data[31:0], edge_lim[0]);
            goal[1] = clamp_goal(data[63:32], edge_lim[1]);
            rate_cap = 0;
            boost = 1'b0;
            for (int a = 0; a < 2; a++) begin
               pos[a] = goal[a];
               vel[a] = 0;
            end
         end
         REQ_SHAKE: begin
            for (int a = 0; a < 2; a++) begin
               shk_on[a] = 1'b1;
               shk_ticks[a] = 0;
               shk_lvl[a] = 0;
               shk_fall[a] = 1'b0;
            end
         end
         default: ;
      endcase
      return {32'(jit[1]), 32'(jit[0]), 32'(pos[1]), 32'(pos[0])};
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      fault_count++;
      $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      logic [RSP_DATA_W-1:0] want;
      if (reset) begin
         for (int a = 0; a < 2; a++) begin
            edge_lim[a] = 0;
            amp_raw[a] = 0;
            shake_len[a] = 0;
            pos[a] = 0;
            vel[a] = 0;
            goal[a] = 0;
            shk_on[a] = 1'b0;
            shk_ticks[a] = 0;
            shk_fall[a] = 1'b0;
            shk_lvl[a] = 0;
            jit[a] = 0;
         end
         rate_cap = 0;
         boost = 1'b0;
         pending_views.delete();
         fault_count = 0;
         owed_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MAX_SCROLL_X: edge_lim[0] = longint'(csr_wdata);
               CSR_MAX_SCROLL_Y: edge_lim[1] = longint'(csr_wdata);
               CSR_SHAKE_AMP_X:  amp_raw[0] = longint'(csr_wdata[15:0]);
               CSR_SHAKE_AMP_Y:  amp_raw[1] = longint'(csr_wdata[15:0]);
               CSR_SHAKE_LEN_X:  shake_len[0] = longint'(csr_wdata[15:0]);
               CSR_SHAKE_LEN_Y:  shake_len[1] = longint'(csr_wdata[15:0]);
               default: ;
            endcase
         end
         // responses first: one taken on this edge never belongs to this edge's request
         if (rsp_tvalid && rsp_tready) begin
            if (pending_views.size() == 0) begin
               flag_mismatch("unexpected response view_x", rsp_tdata[31:0], 32'h0);
            end else begin
               want = pending_views.pop_front();
               for (int f = 0; f < 4; f++) begin
                  if (rsp_tdata[32*f +: 32] !== want[32*f +: 32])
                     flag_mismatch(field_name[f], rsp_tdata[32*f +: 32], want[32*f +: 32]);
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_views.push_back(advance_camera(req_tuser, req_tdata));
         owed_count <= pending_views.size();
      end
   end

endmodule

// ----- sim/scroll_follow_with_shake_tb.sv -----
// top of the scroll follower testbench: clock, reset, register set-up and request stimulus
// with random idling on both sides; depends on sfws_pkg, the block and scroll_follow_with_shake_check
`timescale 1ns / 100ps

module scroll_follow_with_shake_tb;
   import sfws_pkg::*;

   localparam logic [30:0] EDGE_MAX      = 31'h7FFF_FFFF;
   localparam logic [2:0]  REQ_SPARE_LO  = 3'd5;
   localparam logic [2:0]  REQ_SPARE_HI  = 3'd7;
   localparam int          HOLD_CYCLES   = 200;
   localparam int          GLIDE_TICKS   = 1700;
   localparam int          PHASE_ITEMS   = 160;
   // start points chosen so that the glide ends just short of the goals with speed 17000
   localparam logic [31:0] GLIDE_X0      = 32'd2133025077;
   localparam logic [31:0] GLIDE_Y0      = 32'd14458570;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [2:0]              req_tuser = REQ_TICK;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   int                      fault_count;
   int                      owed_count;
   bit                      calm = 1'b0;
   int                      holds_asked = 0;
   int                      holds_done = 0;

   scroll_follow_with_shake u_dut (.*);
   scroll_follow_with_shake_check u_check (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("scroll_follow_with_shake_tb NOT OK");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_target(input logic [30:0] far_edge);
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return $urandom_range(0, far_edge);
      if (r < 82) return $urandom;
      if (r < 90) return {1'b0, far_edge} + $urandom_range(1, 5000);
      if (r < 95) return 32'h8000_0000;
      return 32'h7FFF_FFFF;
   endfunction

   function automatic logic [30:0] pick_edge();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return 31'($urandom_range(0, 40000));
      if (r < 50) return 31'($urandom_range(0, 1 << 20));
      if (r < 70) return 31'($urandom);
      if (r < 88) return EDGE_MAX;
      return 31'h0;
   endfunction

   function automatic logic [15:0] pick_amp();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return 16'($urandom_range(0, 600));
      if (r < 60) return 16'($urandom);
      if (r < 80) return 16'hFFFF;
      return 16'h0;
   endfunction

   function automatic logic [15:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return 16'h0;
      if (r < 55) return 16'($urandom_range(1, 40));
      if (r < 70) return 16'($urandom);
      if (r < 85) return 16'hFFFF;
      return 16'h1;
   endfunction

   // one register write per edge; the caller lowers the enable after the last
   task automatic put_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [30:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [30:0] mx, input logic [30:0] my,
                           input logic [15:0] ax, input logic [15:0] ay,
                           input logic [15:0] lx, input logic [15:0] ly);
      put_reg(CSR_MAX_SCROLL_X, mx);
      put_reg(CSR_MAX_SCROLL_Y, my);
      put_reg(CSR_SHAKE_AMP_X, {15'h0, ax});
      put_reg(CSR_SHAKE_AMP_Y, {15'h0, ay});
      put_reg(CSR_SHAKE_LEN_X, {15'h0, lx});
      put_reg(CSR_SHAKE_LEN_Y, {15'h0, ly});
      csr_we <= 1'b0;
   endtask

   task automatic offer(input logic [2:0] kind, input logic [31:0] tx, input logic [31:0] ty,
                        input logic [29:0] rate);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, rate, ty, tx};
      do @(posedge clock); while (!req_tready);
      // no gaps while the receiver is held off, so the block backs up
      gap = (calm || holds_asked != holds_done) ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait until every response is in, then let the pipeline drain before touching registers
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   initial begin : drain
      int n;
      forever begin
         @(posedge clock);
         if (holds_asked != holds_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done = holds_done + 1;
            rsp_tready <= 1'b1;
         end else begin
            n = calm ? 0 : pick_gap();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [30:0] mx, my;
      logic [2:0]  kind;
      logic [29:0] rate;
      int          pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full-range edges, endless shake on x, longest shake on y with no amplitude
      set_regs(EDGE_MAX, EDGE_MAX, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF);
      offer(REQ_SNAP, 32'h8000_0000, 32'h7FFF_FFFF, 30'h3FFF_FFFF);
      offer(REQ_FOLLOW, 32'h7FFF_FFFF, 32'h0, 30'h3FFF_FFFF);
      repeat (3) offer(REQ_TICK, 32'h0, 32'h0, 30'h0);
      offer(REQ_SHAKE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
      repeat (2) offer(REQ_TICK, 32'h0, 32'h0, 30'h0);
      for (int c = REQ_SPARE_LO; c <= REQ_SPARE_HI; c++)
         offer(3'(c), $urandom, $urandom, 30'($urandom));
      offer(REQ_PAN, 32'h0, 32'h0, 30'h0);
      offer(REQ_TICK, 32'h0, 32'h0, 30'h0);
      settle();

      // short fading shake on x, one-tick shake on y against a zero edge
      set_regs(31'd1000, 31'd0, 16'd700, 16'hFFFF, 16'd22, 16'd1);
      offer(REQ_SNAP, 32'd4000, 32'd0, 30'h0);
      offer(REQ_SHAKE, 32'h0, 32'h0, 30'h0);
      repeat (4) offer(REQ_TICK, 32'h0, 32'h0, 30'h0);
      settle();

      // length cut below the tick count, then a far edge below the position
      set_regs(31'd100, 31'd0, 16'd700, 16'hFFFF, 16'd3, 16'd0);
      offer(REQ_TICK, 32'h0, 32'h0, 30'h0);
      offer(REQ_SHAKE, 32'h0, 32'h0, 30'h0);
      repeat (3) offer(REQ_TICK, 32'h0, 32'h0, 30'h0);
      settle();

      // long glide to build up speed, then a boosted step that overshoots the y goal and saturates x at its goal
      set_regs(EDGE_MAX, EDGE_MAX, 16'd2000, 16'd2000, 16'd0, 16'd40);
      offer(REQ_SNAP, GLIDE_X0, GLIDE_Y0, 30'h0);
      offer(REQ_PAN, 32'h7FFF_FFFF, 32'h0, 30'h3FFF_FFFF);
      holds_asked = holds_asked + 1;
      for (int k = 0; k < GLIDE_TICKS; k++) begin
         if ($urandom_range(0, 49) == 0)
            offer($urandom_range(0, 1) ? REQ_SHAKE : REQ_SPARE_LO, $urandom, $urandom,
                  30'($urandom));
         offer(REQ_TICK, $urandom, $urandom, 30'($urandom));
      end
      offer(REQ_FOLLOW, 32'h7FFF_FFFF, 32'h0, 30'h3FFF_FFFF);
      repeat (3) offer(REQ_TICK, 32'h0, 32'h0, 30'h0);
      settle();

      for (int ph = 0; ph < 4; ph++) begin
         calm = (ph == 2);
         mx = pick_edge();
         my = pick_edge();
         set_regs(mx, my, pick_amp(), pick_amp(), pick_len(), pick_len());
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 52) kind = REQ_TICK;
            else if (pick < 64) kind = REQ_PAN;
            else if (pick < 76) kind = REQ_FOLLOW;
            else if (pick < 82) kind = REQ_SNAP;
            else if (pick < 94) kind = REQ_SHAKE;
            else kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
            pick = $urandom_range(0, 99);
            if (pick < 40) rate = 30'($urandom_range(0, 2000));
            else if (pick < 70) rate = 30'($urandom_range(0, 200000));
            else if (pick < 90) rate = 30'($urandom);
            else rate = $urandom_range(0, 1) ? 30'h3FFF_FFFF : 30'h0;
            offer(kind, pick_target(mx), pick_target(my), rate);
         end
         settle();
      end

      if (fault_count == 0 && owed_count == 0) begin
         $display("scroll_follow_with_shake_tb OK");
      end else begin
         $display("scroll_follow_with_shake_tb NOT OK");
      end
      $finish;
   end

endmodule
